@@ sv/urh_pkg.sv @@
package urh_pkg;

	// Item kinds carried on the input tuser.
	typedef enum logic [1:0] {
		KIND_NAV  = 2'd0,
		KIND_UNDO = 2'd1,
		KIND_REDO = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	// Operation applied to one stack (and its row of cells) in a cycle.
	typedef enum logic [1:0] {
		STK_HOLD  = 2'd0,
		STK_PUSH  = 2'd1,
		STK_POP   = 2'd2,
		STK_CLEAR = 2'd3
	} stk_op_t;

	// Fill status of one stack, sent up to the top level.
	typedef struct packed {
		logic empty;
		logic full;
		logic single;
	} stk_status_t;

	localparam int unsigned KIND_BITS = 2;
	localparam int unsigned FLAG_BITS = 3;

endpackage

@@ sv/undo_redo_history_stacks.sv @@
// Undo/redo history: two bounded stacks of entries (id plus data word).
// Input stream s_*: s_tuser carries the kind (navigate, undo, redo), s_tdata
// the entry id and data word used by navigate. Output stream m_*: one word per
// input word, with the current entry in m_tdata and the status flags in
// m_tuser. The home id comes from cfg_wdata, written whenever cfg_we is high.
// Each stack is a row of DEPTH cells; a push shifts the row one cell deeper,
// a pop shifts it one cell toward the top, so the top two entries always sit
// in fixed cells.
// The result is captured in the output register when the input word is
// accepted. Throughput: one word per cycle while the receiver takes each
// result, set by the single output register that s_tready waits on.
// When the receiver stalls, the result is held and s_tready stays low until
// it is taken; no further word is accepted meanwhile.
// Reset empties both stacks, clears the home id to zero and drops any
// pending result; entries above the stack counts are never read.
module undo_redo_history_stacks #(
	parameter int unsigned DEPTH     = 16,
	parameter int unsigned ID_BITS   = 16,
	parameter int unsigned DATA_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [ID_BITS-1:0]       cfg_wdata,     // home_entry
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [((ID_BITS + DATA_BITS + 7) / 8) * 8 - 1:0] s_tdata, // entry_id, entry_data
	input  logic [urh_pkg::KIND_BITS-1:0] s_tuser,  // kind
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [((ID_BITS + DATA_BITS + 7) / 8) * 8 - 1:0] m_tdata, // out_entry, out_data
	output logic [urh_pkg::FLAG_BITS-1:0] m_tuser   // ok, went_home, push_dropped
);

	localparam int unsigned EW = ID_BITS + DATA_BITS;
	localparam int unsigned TW = ((EW + 7) / 8) * 8;

	logic [ID_BITS-1:0]   home_q;
	logic                 m_tvalid_q;
	logic                 ok_q;
	logic                 went_home_q;
	logic                 dropped_q;
	logic [ID_BITS-1:0]   out_id_q;
	logic [DATA_BITS-1:0] out_data_q;

	urh_pkg::kind_t       kind;
	logic                 in_acc;
	logic [EW-1:0]        in_entry;

	urh_pkg::stk_op_t     undo_op;
	urh_pkg::stk_op_t     redo_op;
	logic [EW-1:0]        undo_push;
	logic [EW-1:0]        redo_push;
	logic [EW-1:0]        undo_top;
	logic [EW-1:0]        undo_next;
	logic [EW-1:0]        redo_top;
	logic [EW-1:0]        redo_next;
	urh_pkg::stk_status_t undo_st;
	urh_pkg::stk_status_t redo_st;

	logic                 ok_d;
	logic                 went_home_d;
	logic                 dropped_d;
	logic [ID_BITS-1:0]   out_id_d;
	logic [DATA_BITS-1:0] out_data_d;

	assign kind     = urh_pkg::kind_t'(s_tuser);
	assign s_tready = !m_tvalid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;
	assign in_entry = s_tdata[EW-1:0];

	// Entries are packed {data, id}; the id sits in the low bits.
	always_comb begin
		undo_op     = urh_pkg::STK_HOLD;
		redo_op     = urh_pkg::STK_HOLD;
		undo_push   = in_entry;
		redo_push   = undo_top;
		ok_d        = 1'b0;
		went_home_d = 1'b0;
		dropped_d   = 1'b0;
		out_id_d    = '0;
		out_data_d  = '0;
		case (kind)
			urh_pkg::KIND_NAV: begin
				undo_op   = urh_pkg::STK_PUSH;
				redo_op   = urh_pkg::STK_CLEAR;
				ok_d      = 1'b1;
				dropped_d = undo_st.full;
			end
			urh_pkg::KIND_UNDO: begin
				if (!undo_st.empty) begin
					undo_op   = urh_pkg::STK_POP;
					redo_op   = urh_pkg::STK_PUSH;
					ok_d      = 1'b1;
					dropped_d = redo_st.full;
					if (undo_st.single) begin
						out_id_d    = home_q;
						went_home_d = 1'b1;
					end else begin
						out_id_d   = undo_next[ID_BITS-1:0];
						out_data_d = undo_next[EW-1:ID_BITS];
					end
				end
			end
			urh_pkg::KIND_REDO: begin
				if (!redo_st.empty) begin
					redo_op    = urh_pkg::STK_POP;
					undo_op    = urh_pkg::STK_PUSH;
					undo_push  = redo_top;
					ok_d       = 1'b1;
					dropped_d  = undo_st.full;
					out_id_d   = redo_top[ID_BITS-1:0];
					out_data_d = redo_top[EW-1:ID_BITS];
				end
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
		if (!in_acc) begin
			undo_op = urh_pkg::STK_HOLD;
			redo_op = urh_pkg::STK_HOLD;
		end
	end

	urh_stack #(.DEPTH(DEPTH), .W(EW)) u_undo (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (undo_op),
		.push_val (undo_push),
		.top      (undo_top),
		.next     (undo_next),
		.status   (undo_st)
	);

	urh_stack #(.DEPTH(DEPTH), .W(EW)) u_redo (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (redo_op),
		.push_val (redo_push),
		.top      (redo_top),
		.next     (redo_next),
		.status   (redo_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				home_q <= cfg_wdata;
			end
			if (in_acc) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Hold the result until the receiver takes it.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ok_q        <= ok_d;
			went_home_q <= went_home_d;
			dropped_q   <= dropped_d;
			out_id_q    <= out_id_d;
			out_data_q  <= out_data_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TW'({out_data_q, out_id_q});
	assign m_tuser  = {dropped_q, went_home_q, ok_q};

	a_undo_empty_fails: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && kind == urh_pkg::KIND_UNDO && undo_st.empty)
		|=> (m_tvalid_q && !ok_q))
		else $error("undo on empty history reported success");

	a_home_implies_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && went_home_q) |-> (ok_q && out_data_q == '0))
		else $error("home result without success or with data");

	a_redo_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && kind == urh_pkg::KIND_REDO && redo_st.single)
		|=> redo_st.empty)
		else $error("redo of last entry left redo stack non-empty");

endmodule

@@ sv/urh_cell.sv @@
module urh_cell #(
	parameter int unsigned W = 48
) (
	input  logic            clk,
	input  urh_pkg::stk_op_t op,
	input  logic [W-1:0]    from_up,
	input  logic [W-1:0]    from_down,
	output logic [W-1:0]    value
);

	logic [W-1:0] value_q;

	// Push moves every entry one cell deeper, pop one cell toward the top.
	always_ff @(posedge clk) begin
		case (op)
			urh_pkg::STK_PUSH: value_q <= from_up;
			urh_pkg::STK_POP:  value_q <= from_down;
			default:           value_q <= value_q;
		endcase
	end

	assign value = value_q;

endmodule

@@ sv/urh_stack.sv @@
module urh_stack #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned W     = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  urh_pkg::stk_op_t      op,
	input  logic [W-1:0]          push_val,
	output logic [W-1:0]          top,
	output logic [W-1:0]          next,
	output urh_pkg::stk_status_t  status
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [CW-1:0]    count_q;
	logic [W-1:0]     cell_val [DEPTH];
	urh_pkg::stk_op_t cell_op;
	logic             full;
	logic             empty;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	// Drop a push onto a full stack and a pop from an empty one.
	always_comb begin
		cell_op = urh_pkg::STK_HOLD;
		case (op)
			urh_pkg::STK_PUSH: if (!full)  cell_op = urh_pkg::STK_PUSH;
			urh_pkg::STK_POP:  if (!empty) cell_op = urh_pkg::STK_POP;
			default:           cell_op = urh_pkg::STK_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (op)
				urh_pkg::STK_CLEAR: count_q <= '0;
				urh_pkg::STK_PUSH:  if (!full)  count_q <= count_q + CW'(1);
				urh_pkg::STK_POP:   if (!empty) count_q <= count_q - CW'(1);
				default:            count_q <= count_q;
			endcase
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [W-1:0] up_val;
		logic [W-1:0] down_val;

		if (i == 0) begin : g_first
			assign up_val = push_val;
		end else begin : g_mid
			assign up_val = cell_val[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign down_val = cell_val[i];
		end else begin : g_inner
			assign down_val = cell_val[i+1];
		end

		urh_cell #(.W(W)) u_cell (
			.clk       (clk),
			.op        (cell_op),
			.from_up   (up_val),
			.from_down (down_val),
			.value     (cell_val[i])
		);
	end

	assign top = cell_val[0];

	if (DEPTH > 1) begin : g_next
		assign next = cell_val[1];
	end else begin : g_no_next
		assign next = '0;
	end

	assign status.empty  = empty;
	assign status.full   = full;
	assign status.single = (count_q == CW'(1));

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("stack count above depth");

	a_full_push_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(op == urh_pkg::STK_PUSH && full) |=> $stable(count_q))
		else $error("push onto full stack changed the count");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(op == urh_pkg::STK_CLEAR) |=> (count_q == '0))
		else $error("clear left entries on the stack");

endmodule
